FILE: design/mcls_pkg.sv
`timescale 1ns / 1ps
package mcls_pkg;

  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int HEIGHT_BITS_DEF = 20;

  // Fixed field widths of the channels
  localparam int HEIGHT_W = 20;
  localparam int LEVEL_W  = 20;
  localparam int TARGET_W = 31;
  localparam int SUM_W    = 31;

  localparam logic [SUM_W-1:0] SUM_CAP = 31'h7FFF_FFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } ex_stat_t;

endpackage

FILE: design/mcls_ram.sv
`timescale 1ns / 1ps
module mcls_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mcls_excess.sv
`timescale 1ns / 1ps
module mcls_excess #(
  parameter int MAX_ITEMS   = 1024,
  parameter int HEIGHT_BITS = 20,
  parameter int CNT_W       = $clog2(MAX_ITEMS + 1),
  parameter int AW          = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [HEIGHT_BITS-1:0]  level,
  input  logic [CNT_W-1:0]        count,
  output logic                    rd_en,
  output logic [AW-1:0]           rd_addr,
  input  logic [HEIGHT_BITS-1:0]  rd_data,
  output logic [mcls_pkg::SUM_W-1:0] sum,
  output mcls_pkg::ex_stat_t      stat
);
  import mcls_pkg::*;

  localparam int ACC_W = ((HEIGHT_BITS > SUM_W) ? HEIGHT_BITS : SUM_W) + 1;

  logic             busy_r, busy_nxt;
  logic             rd_valid_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [ACC_W-1:0] acc;
  logic [HEIGHT_BITS-1:0] diff;
  logic             done;

  assign rd_en   = busy_r && (idx_r < count);
  assign rd_addr = idx_r[AW-1:0];
  assign done    = busy_r && (idx_r == count) && !rd_valid_r;

  assign diff = (rd_data > level) ? (rd_data - level) : '0;
  assign acc  = ACC_W'(sum_r) + ACC_W'(diff);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      sum_nxt  = '0;
    end else begin
      if (rd_en) begin
        idx_nxt = idx_r + 1'b1;
      end
      // saturate the running total at the cap
      if (rd_valid_r) begin
        sum_nxt = (acc > ACC_W'(SUM_CAP)) ? SUM_CAP : acc[SUM_W-1:0];
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      rd_valid_r <= 1'b0;
      idx_r      <= '0;
      sum_r      <= '0;
    end else begin
      busy_r     <= busy_nxt;
      rd_valid_r <= rd_en && !start;
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
    end
  end

  assign sum       = sum_r;
  assign stat.busy = busy_r;
  assign stat.done = done;

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> busy_r)
    else $error("read data returned while unit idle");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !start) |=> !busy_r)
    else $error("unit still busy after done");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= count))
    else $error("walk index ran past item count");

endmodule

FILE: design/max_cut_level_search.sv
`timescale 1ns / 1ps
// max_cut_level_search
//
// Heights enter on the in_ channel (in_valid / in_ready), one item per cycle
// while the block is loading. Each accepted height is written to the height
// memory and the running maximum is updated; items beyond MAX_ITEMS are
// dropped. An item with in_last set ends the set and starts the search, and
// in_ready stays low until the result has entered the output register.
// The search bisects levels 0 .. max height. Each probe walks the memory once
// through a single subtract/accumulate unit. The number of probes is at most
// log2(max height + 1) + 1. One result per set leaves on the out_ channel
// (out_valid / out_ready) from an output register; loading of the next set
// proceeds while it waits. If a second search finishes before the first
// result is taken, it holds there until out_ready frees the register.
// cfg_we / cfg_wdata write the target total at any clock edge; keep it stable
// while a search runs.
// Reset (rst_n low, synchronous) clears the set, the target and out_valid;
// the memory needs no clearing since only entries of the current set are read.
module max_cut_level_search #(
  parameter int MAX_ITEMS   = mcls_pkg::MAX_ITEMS_DEF,
  parameter int HEIGHT_BITS = mcls_pkg::HEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcls_pkg::HEIGHT_W-1:0] in_height,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcls_pkg::LEVEL_W-1:0]  out_cut_level,
  input  logic                          cfg_we,
  input  logic [mcls_pkg::TARGET_W-1:0] cfg_wdata
);
  import mcls_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int HB    = HEIGHT_BITS;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_MID  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [TARGET_W-1:0] target_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [HB-1:0]       max_r, max_nxt;
  logic [HB:0]         low_r, low_nxt;
  logic [HB-1:0]       high_r, high_nxt;
  logic [HB-1:0]       mid_r, mid_nxt;
  logic [HB-1:0]       best_r, best_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;

  logic          accept;
  logic          store;
  logic [HB-1:0] h_in;
  logic [HB-1:0] max_upd;
  logic [HB+1:0] mid_sum;
  logic          ex_start;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [HB-1:0] rd_data;
  logic [SUM_W-1:0] ex_sum;
  ex_stat_t      ex_stat;

  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign h_in     = HB'(in_height);
  assign store    = accept && (count_r < CNT_W'(MAX_ITEMS));
  assign max_upd  = (store && (h_in > max_r)) ? h_in : max_r;
  assign mid_sum  = (HB+2)'(low_r) + (HB+2)'(high_r);
  assign ex_start = (state_r == S_MID) && (low_r <= {1'b0, high_r});

  mcls_ram #(
    .WIDTH (HB),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (store),
    .waddr (count_r[AW-1:0]),
    .wdata (h_in),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mcls_excess #(
    .MAX_ITEMS   (MAX_ITEMS),
    .HEIGHT_BITS (HB)
  ) u_excess (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ex_start),
    .level   (mid_nxt),
    .count   (count_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .sum     (ex_sum),
    .stat    (ex_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    max_nxt       = max_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (store) begin
          count_nxt = count_r + 1'b1;
          max_nxt   = max_upd;
        end
        if (accept && in_last) begin
          low_nxt   = '0;
          high_nxt  = max_upd;
          best_nxt  = '0;
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        if (ex_start) begin
          mid_nxt   = mid_sum[HB:1];
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAIT: begin
        if (ex_stat.done) begin
          if (ex_sum >= target_r) begin
            best_nxt  = mid_r;
            low_nxt   = (HB+1)'(mid_r) + 1'b1;
            state_nxt = S_MID;
          end else if (mid_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            high_nxt  = mid_r - 1'b1;
            state_nxt = S_MID;
          end
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = LEVEL_W'(best_r);
          count_nxt     = '0;
          max_nxt       = '0;
          low_nxt       = '0;
          high_nxt      = '0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      target_r    <= '0;
      count_r     <= '0;
      max_r       <= '0;
      low_r       <= '0;
      high_r      <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      max_r       <= max_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mid_r       <= mid_nxt;
    out_level_r <= out_level_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cut_level = out_level_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("item count above store depth");
  a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> ((HB+1)'(mid_r) >= low_r && mid_r <= high_r))
    else $error("probe level outside search window");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ex_stat.done |-> (state_r == S_WAIT))
    else $error("excess unit finished outside a probe");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ex_start |-> !ex_stat.busy)
    else $error("probe started while excess unit busy");

endmodule
